// ----- rtl/core/wlcu_pkg.sv -----
// Shared types, constants and rule-match function for the weighted life cell update block.
package wlcu_pkg;

	// Number of rule entries that take part in a birth or survival match
	localparam int RULE_ENTRIES = 10;

	localparam int TAPS          = 24;
	localparam int LANES         = 3;
	localparam int TAPS_PER_LANE = TAPS / LANES;
	localparam int WEIGHT_W      = 8;
	localparam int PART_W        = 11;
	localparam int SUM_W         = 13;
	localparam int WREG_W        = 64;
	localparam int RREG_W        = 40;
	localparam int RULES_W       = 2 * RREG_W;
	localparam int CFG_IDX_W     = 3;

	// Register reset values
	localparam logic [WREG_W-1:0] WEIGHTS_A_RST = 64'h0101_0000_0000_0000;
	localparam logic [WREG_W-1:0] WEIGHTS_B_RST = 64'h0100_0001_0100_0001;
	localparam logic [WREG_W-1:0] WEIGHTS_C_RST = 64'h0000_0000_0000_0101;
	localparam logic [RREG_W-1:0] BORN_LOW_RST  = 40'hFF_FFFF_FF03;
	localparam logic [RREG_W-1:0] BORN_HIGH_RST = 40'hFF_FFFF_FFFF;
	localparam logic [RREG_W-1:0] STAY_LOW_RST  = 40'hFF_FFFF_0302;
	localparam logic [RREG_W-1:0] STAY_HIGH_RST = 40'hFF_FFFF_FFFF;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHTS_A = 3'd0,
		CFG_WEIGHTS_B = 3'd1,
		CFG_WEIGHTS_C = 3'd2,
		CFG_BORN_LOW  = 3'd3,
		CFG_BORN_HIGH = 3'd4,
		CFG_STAY_LOW  = 3'd5,
		CFG_STAY_HIGH = 3'd6
	} cfg_reg_t;

	// Cell state codes
	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_KIND1 = 2'd1,
		ST_KIND2 = 2'd2
	} cell_state_t;

	// Control that travels alongside the lane partial sums
	typedef struct packed {
		logic       valid;
		logic [1:0] center;
		logic       parity;
	} cell_ctrl_t;

	// True when sum equals any active signed byte entry of a packed rule list
	function automatic logic rule_match(input logic [RULES_W-1:0] rules,
	                                    input logic signed [SUM_W-1:0] sum);
		logic              hit;
		logic signed [7:0] entry;
		hit = 1'b0;
		for (int i = 0; i < RULE_ENTRIES; i++) begin
			entry = rules[8*i +: 8];
			if (SUM_W'(entry) == sum) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ----- rtl/core/wlcu_lane.sv -----
// One lane: weighted sum of eight neighbor taps, registered.
module wlcu_lane (
	input  logic                                         clk,
	input  logic [wlcu_pkg::TAPS_PER_LANE-1:0]           bits,
	input  logic [wlcu_pkg::WREG_W-1:0]                  weights,
	output logic signed [wlcu_pkg::PART_W-1:0]           part_s1
);

	logic signed [wlcu_pkg::PART_W-1:0] part;

	// Add the weight of every occupied tap
	always_comb begin
		logic signed [wlcu_pkg::WEIGHT_W-1:0] w;
		part = '0;
		for (int k = 0; k < wlcu_pkg::TAPS_PER_LANE; k++) begin
			w = weights[wlcu_pkg::WEIGHT_W*k +: wlcu_pkg::WEIGHT_W];
			if (bits[k]) begin
				part = part + wlcu_pkg::PART_W'(w);
			end
		end
	end

	// Hold the partial sum for the merge stage
	always_ff @(posedge clk) begin
		part_s1 <= part;
	end

endmodule

// ----- rtl/core/wlcu_merge.sv -----
// Merge stage: total of the lane sums, rule match and next-state decision.
module wlcu_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wlcu_pkg::cell_ctrl_t                  ctrl_s1,
	input  logic signed [wlcu_pkg::PART_W-1:0]    part0_s1,
	input  logic signed [wlcu_pkg::PART_W-1:0]    part1_s1,
	input  logic signed [wlcu_pkg::PART_W-1:0]    part2_s1,
	input  logic [wlcu_pkg::RULES_W-1:0]          born_rules,
	input  logic [wlcu_pkg::RULES_W-1:0]          stay_rules,
	output logic                                  done_s2,
	output logic [1:0]                            next_s2,
	output logic signed [wlcu_pkg::SUM_W-1:0]     sum_s2
);

	logic signed [wlcu_pkg::SUM_W-1:0] sum;
	logic                              born_hit;
	logic                              stay_hit;
	wlcu_pkg::cell_state_t             next;

	// Combine the three lanes
	assign sum = wlcu_pkg::SUM_W'(part0_s1) + wlcu_pkg::SUM_W'(part1_s1)
	           + wlcu_pkg::SUM_W'(part2_s1);

	assign born_hit = wlcu_pkg::rule_match(born_rules, sum);
	assign stay_hit = wlcu_pkg::rule_match(stay_rules, sum);

	// Live cells survive on a stay match; empty (or code three) cells follow the birth rule
	always_comb begin
		unique case (ctrl_s1.center)
			wlcu_pkg::ST_KIND1: next = stay_hit ? wlcu_pkg::ST_KIND1 : wlcu_pkg::ST_EMPTY;
			wlcu_pkg::ST_KIND2: next = stay_hit ? wlcu_pkg::ST_KIND2 : wlcu_pkg::ST_EMPTY;
			default: begin
				if (born_hit) begin
					next = ctrl_s1.parity ? wlcu_pkg::ST_KIND1 : wlcu_pkg::ST_KIND2;
				end else begin
					next = wlcu_pkg::ST_EMPTY;
				end
			end
		endcase
	end

	// Strobe the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= ctrl_s1.valid;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		next_s2 <= next;
		sum_s2  <= sum;
	end

endmodule

// ----- rtl/core/weighted_life_cell_update_top.sv -----
// Top level of the weighted life cell update block: config registers, lanes and merge.
//
// channel  | handshake        | payload
// ---------+------------------+------------------------------------------------
// input    | start, busy      | neighbor_bits, center_state, cell_parity
// result   | done             | next_state, weighted_sum
// config   | cfg_we           | cfg_index, cfg_data
//
// One cell enters every cycle; busy stays low, so a start beat is always taken.
// Each result shows on done once its start beat has passed the lane adder registers
// and then the lane merge and rule compare registers.
// Reset loads the default rule (B3/S23 on the inner ring) and clears the pipeline.
// The receiver cannot stall; results leave in the order the cells arrived.
module weighted_life_cell_update_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [wlcu_pkg::TAPS-1:0]              neighbor_bits,
	input  logic [1:0]                             center_state,
	input  logic                                   cell_parity,
	output logic                                   done,
	output logic [1:0]                             next_state,
	output logic signed [wlcu_pkg::SUM_W-1:0]      weighted_sum,
	input  logic                                   cfg_we,
	input  logic [wlcu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wlcu_pkg::WREG_W-1:0]            cfg_data
);

	logic [wlcu_pkg::WREG_W-1:0] weights_a_q;
	logic [wlcu_pkg::WREG_W-1:0] weights_b_q;
	logic [wlcu_pkg::WREG_W-1:0] weights_c_q;
	logic [wlcu_pkg::RREG_W-1:0] born_low_q;
	logic [wlcu_pkg::RREG_W-1:0] born_high_q;
	logic [wlcu_pkg::RREG_W-1:0] stay_low_q;
	logic [wlcu_pkg::RREG_W-1:0] stay_high_q;

	logic                               valid_s1;
	logic [1:0]                         center_s1;
	logic                               parity_s1;
	wlcu_pkg::cell_ctrl_t               ctrl_s1;
	logic signed [wlcu_pkg::PART_W-1:0] part0_s1;
	logic signed [wlcu_pkg::PART_W-1:0] part1_s1;
	logic signed [wlcu_pkg::PART_W-1:0] part2_s1;

	assign busy = 1'b0;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_a_q <= wlcu_pkg::WEIGHTS_A_RST;
			weights_b_q <= wlcu_pkg::WEIGHTS_B_RST;
			weights_c_q <= wlcu_pkg::WEIGHTS_C_RST;
			born_low_q  <= wlcu_pkg::BORN_LOW_RST;
			born_high_q <= wlcu_pkg::BORN_HIGH_RST;
			stay_low_q  <= wlcu_pkg::STAY_LOW_RST;
			stay_high_q <= wlcu_pkg::STAY_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wlcu_pkg::CFG_WEIGHTS_A: weights_a_q <= cfg_data;
				wlcu_pkg::CFG_WEIGHTS_B: weights_b_q <= cfg_data;
				wlcu_pkg::CFG_WEIGHTS_C: weights_c_q <= cfg_data;
				wlcu_pkg::CFG_BORN_LOW:  born_low_q  <= cfg_data[wlcu_pkg::RREG_W-1:0];
				wlcu_pkg::CFG_BORN_HIGH: born_high_q <= cfg_data[wlcu_pkg::RREG_W-1:0];
				wlcu_pkg::CFG_STAY_LOW:  stay_low_q  <= cfg_data[wlcu_pkg::RREG_W-1:0];
				wlcu_pkg::CFG_STAY_HIGH: stay_high_q <= cfg_data[wlcu_pkg::RREG_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the beat valid into the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	// Carry the cell state and parity alongside the lane sums
	always_ff @(posedge clk) begin
		center_s1 <= center_state;
		parity_s1 <= cell_parity;
	end

	assign ctrl_s1 = {valid_s1, center_s1, parity_s1};

	wlcu_lane u_lane0 (
		.clk     (clk),
		.bits    (neighbor_bits[0 +: wlcu_pkg::TAPS_PER_LANE]),
		.weights (weights_a_q),
		.part_s1 (part0_s1)
	);

	wlcu_lane u_lane1 (
		.clk     (clk),
		.bits    (neighbor_bits[wlcu_pkg::TAPS_PER_LANE +: wlcu_pkg::TAPS_PER_LANE]),
		.weights (weights_b_q),
		.part_s1 (part1_s1)
	);

	wlcu_lane u_lane2 (
		.clk     (clk),
		.bits    (neighbor_bits[2*wlcu_pkg::TAPS_PER_LANE +: wlcu_pkg::TAPS_PER_LANE]),
		.weights (weights_c_q),
		.part_s1 (part2_s1)
	);

	wlcu_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.part0_s1   (part0_s1),
		.part1_s1   (part1_s1),
		.part2_s1   (part2_s1),
		.born_rules ({born_high_q, born_low_q}),
		.stay_rules ({stay_high_q, stay_low_q}),
		.done_s2    (done),
		.next_s2    (next_state),
		.sum_s2     (weighted_sum)
	);

endmodule

// ----- rtl/core/wlcu_checker.sv -----
// Port-level checker for the weighted life cell update block, with its bind.
module wlcu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          center_state,
	input logic                                done,
	input logic [1:0]                          next_state,
	input logic signed [wlcu_pkg::SUM_W-1:0]   weighted_sum
);

	// Every accepted beat yields a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(arst_n, 2) && $past(start && !busy, 2) |-> done)
		else $error("accepted beat produced no result");

	// No result without an accepted beat
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted beat");

	// Result state is a legal code
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> next_state != 2'd3)
		else $error("illegal next_state code");

	// A live cell either keeps its kind or empties
	a_live_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(center_state, 2) == 2'd1 || $past(center_state, 2) == 2'd2)
		|-> (next_state == 2'd0 || next_state == $past(center_state, 2)))
		else $error("live cell changed kind");

	// Result sum stays in the reachable range
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (weighted_sum >= -13'sd3072 && weighted_sum <= 13'sd3048))
		else $error("weighted_sum out of range");

endmodule

bind weighted_life_cell_update_top wlcu_checker u_wlcu_checker (.*);

// ----- tb/weighted_life_cell_update_top_test.sv -----
// Self-checking testbench for the weighted life cell update block: directed table, then random rule phases.
module weighted_life_cell_update_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wlcu_pkg::*;

	localparam int PIPE_DEPTH   = 2;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_CELLS = 700;
	localparam int CALM_TAIL    = 120;

	localparam logic [1:0]           CENTER_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG    = 3'd7;

	// Taps of the inner 3x3 ring, where the default rule puts unit weights
	localparam logic [TAPS-1:0] ROW_ABOVE  = 24'h0001C0;
	localparam logic [TAPS-1:0] SIDES      = 24'h001800;
	localparam logic [TAPS-1:0] ROW_BELOW  = 24'h038000;
	localparam logic [TAPS-1:0] INNER_RING = ROW_ABOVE | SIDES | ROW_BELOW;

	typedef struct packed {
		logic [1:0]               state;
		logic signed [SUM_W-1:0]  wsum;
	} cell_result_t;

	typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [TAPS-1:0]        bits;
		logic [1:0]             center;
		logic                   parity;
		logic [CFG_IDX_W-1:0]   idx;
		logic [WREG_W-1:0]      data;
		logic                   typed;
		cell_result_t           outcome;
	} plan_step_t;

	typedef enum {FILL_FULL, FILL_SMALL, FILL_BINARY, FILL_EXTREME, FILL_RULE} fill_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    start         = 1'b0;
	logic                    busy;
	logic [TAPS-1:0]         neighbor_bits = '0;
	logic [1:0]              center_state  = '0;
	logic                    cell_parity   = 1'b0;
	logic                    done;
	logic [1:0]              next_state;
	logic signed [SUM_W-1:0] weighted_sum;
	logic                    cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index     = '0;
	logic [WREG_W-1:0]       cfg_data      = '0;

	// Shadow copy of the rule registers
	logic [WREG_W-1:0] wt_a    = WEIGHTS_A_RST;
	logic [WREG_W-1:0] wt_b    = WEIGHTS_B_RST;
	logic [WREG_W-1:0] wt_c    = WEIGHTS_C_RST;
	logic [RREG_W-1:0] born_lo = BORN_LOW_RST;
	logic [RREG_W-1:0] born_hi = BORN_HIGH_RST;
	logic [RREG_W-1:0] stay_lo = STAY_LOW_RST;
	logic [RREG_W-1:0] stay_hi = STAY_HIGH_RST;

	cell_result_t pending_cells[$];
	plan_step_t   plan[$];
	cell_result_t oldest;
	logic         beat_typed   = 1'b0;
	cell_result_t beat_outcome = '0;

	int mismatches     = 0;
	int cells_checked  = 0;
	int cells_driven   = 0;
	int writes_done    = 0;
	int quiet_cycles   = 0;

	always #2 clk = ~clk;

	weighted_life_cell_update_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.neighbor_bits (neighbor_bits),
		.center_state  (center_state),
		.cell_parity   (cell_parity),
		.done          (done),
		.next_state    (next_state),
		.weighted_sum  (weighted_sum),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// True when the sum equals one of the active signed entries of a rule list
	function automatic logic sum_listed(input logic [RULES_W-1:0] list,
	                                    input logic signed [SUM_W-1:0] s);
		logic signed [7:0] entry;
		for (int i = 0; i < RULE_ENTRIES; i++) begin
			entry = list[8*i +: 8];
			if (entry == s) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Next state and weighted sum of one cell under the shadow rule
	function automatic cell_result_t predict_cell(input logic [TAPS-1:0] bits,
	                                              input logic [1:0] center,
	                                              input logic parity);
		logic [3*WREG_W-1:0]     all_w;
		logic signed [7:0]       w;
		logic signed [SUM_W-1:0] acc;
		cell_result_t            r;
		all_w = {wt_c, wt_b, wt_a};
		acc = '0;
		for (int t = 0; t < TAPS; t++) begin
			if (bits[t]) begin
				w = all_w[8*t +: 8];
				acc = acc + w;
			end
		end
		r.wsum = acc;
		if (center == ST_KIND1 || center == ST_KIND2) begin
			r.state = sum_listed({stay_hi, stay_lo}, acc) ? center : ST_EMPTY;
		end else if (sum_listed({born_hi, born_lo}, acc)) begin
			r.state = parity ? ST_KIND1 : ST_KIND2;
		end else begin
			r.state = ST_EMPTY;
		end
		return r;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
	                                    input logic [WREG_W-1:0] d);
		case (idx)
			CFG_WEIGHTS_A: wt_a = d;
			CFG_WEIGHTS_B: wt_b = d;
			CFG_WEIGHTS_C: wt_c = d;
			CFG_BORN_LOW:  born_lo = d[RREG_W-1:0];
			CFG_BORN_HIGH: born_hi = d[RREG_W-1:0];
			CFG_STAY_LOW:  stay_lo = d[RREG_W-1:0];
			CFG_STAY_HIGH: stay_hi = d[RREG_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic cell_result_t outcome(input logic [1:0] st, input int s);
		cell_result_t r;
		r.state = st;
		r.wsum = SUM_W'(s);
		return r;
	endfunction

	function automatic void add_cell(input logic [TAPS-1:0] bits, input logic [1:0] center,
	                                 input logic parity, input logic typed,
	                                 input cell_result_t res);
		plan_step_t s;
		s = '0;
		s.kind = STEP_CELL;
		s.bits = bits;
		s.center = center;
		s.parity = parity;
		s.typed = typed;
		s.outcome = res;
		plan.push_back(s);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [WREG_W-1:0] d);
		plan_step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.idx = idx;
		s.data = d;
		plan.push_back(s);
	endfunction

	// Eight random bytes drawn from the chosen range
	function automatic logic [WREG_W-1:0] rand_bytes(input fill_t mode);
		logic [WREG_W-1:0] v;
		for (int k = 0; k < 8; k++) begin
			case (mode)
				FILL_FULL:    v[8*k +: 8] = 8'($urandom);
				FILL_SMALL:   v[8*k +: 8] = 8'($urandom_range(0, 4) - 2);
				FILL_BINARY:  v[8*k +: 8] = 8'($urandom_range(0, 1));
				FILL_EXTREME: begin
					case ($urandom_range(0, 3))
						0:       v[8*k +: 8] = 8'h80;
						1:       v[8*k +: 8] = 8'h7F;
						2:       v[8*k +: 8] = 8'hFF;
						default: v[8*k +: 8] = 8'h00;
					endcase
				end
				default:      v[8*k +: 8] = 8'($urandom_range(0, 12) - 4);
			endcase
		end
		return v;
	endfunction

	// Present one cell and hold it until the start beat is taken
	task automatic send_cell(input logic [TAPS-1:0] bits, input logic [1:0] center,
	                         input logic parity, input logic typed, input cell_result_t res);
		neighbor_bits = bits;
		center_state = center;
		cell_parity = parity;
		beat_typed = typed;
		beat_outcome = res;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		cells_driven++;
	endtask

	// Drop start, wait for every result, then let the pipeline empty
	task automatic settle();
		if (start || pending_cells.size() != 0) begin
			start = 1'b0;
			while (pending_cells.size() != 0) @(negedge clk);
			repeat (PIPE_DEPTH) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WREG_W-1:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		apply_write(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
		writes_done++;
	endtask

	task automatic pause_start(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Record accepted cells, check result beats, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (beat_typed) begin
					pending_cells.push_back(beat_outcome);
				end else begin
					pending_cells.push_back(predict_cell(neighbor_bits, center_state, cell_parity));
				end
			end
			if (done) begin
				if (pending_cells.size() == 0) begin
					$error("result beat with nothing expected: next_state %0d weighted_sum %0d",
					       next_state, weighted_sum);
					mismatches++;
				end else begin
					oldest = pending_cells.pop_front();
					cells_checked++;
					if (next_state !== oldest.state) begin
						$error("next_state: expected %0d, got %0d", oldest.state, next_state);
						mismatches++;
					end
					if (weighted_sum !== oldest.wsum) begin
						$error("weighted_sum: expected %0d, got %0d", oldest.wsum, weighted_sum);
						mismatches++;
					end
				end
			end
			quiet_cycles = ((start && !busy) || done) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a beat", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		plan_step_t      step;
		logic [TAPS-1:0] bits;
		logic [1:0]      center;
		fill_t           wmode;
		fill_t           rmode;
		int              idle_pct;
		int              dmode;
		int              base;
		int              phases;
		int              directed_cells;

		// Default rule: B3/S23 on the inner ring, outer ring weightless
		add_cell(24'h000000, ST_EMPTY, 1'b0, 1'b1, outcome(ST_EMPTY, 0));
		add_cell(24'hFFFFFF, ST_EMPTY, 1'b0, 1'b1, outcome(ST_EMPTY, 8));
		add_cell(ROW_ABOVE, ST_EMPTY, 1'b0, 1'b1, outcome(ST_KIND2, 3));
		add_cell(ROW_ABOVE, ST_EMPTY, 1'b1, 1'b1, outcome(ST_KIND1, 3));
		add_cell(SIDES, ST_KIND1, 1'b0, 1'b1, outcome(ST_KIND1, 2));
		add_cell(ROW_ABOVE, ST_KIND2, 1'b1, 1'b1, outcome(ST_KIND2, 3));
		add_cell(ROW_ABOVE | 24'h000800, ST_KIND1, 1'b0, 1'b1, outcome(ST_EMPTY, 4));
		add_cell(~INNER_RING, ST_KIND2, 1'b0, 1'b1, outcome(ST_EMPTY, 0));
		// center code three counts as an empty cell
		add_cell(ROW_ABOVE, CENTER_UNUSED, 1'b1, 1'b1, outcome(ST_KIND1, 3));
		add_cell(SIDES, CENTER_UNUSED, 1'b0, 1'b1, outcome(ST_EMPTY, 2));
		add_cell(INNER_RING, ST_KIND1, 1'b1, 1'b0, '0);
		// Extreme weights; the 0xFF rule entries match a sum of -1
		add_write(CFG_WEIGHTS_A, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(CFG_WEIGHTS_B, 64'h7F7F_7F7F_7F7F_7F7F);
		add_write(CFG_WEIGHTS_C, 64'h8080_8080_8080_8080);
		add_cell(24'h000001, ST_EMPTY, 1'b0, 1'b1, outcome(ST_KIND2, -1));
		add_cell(24'h00FF00, ST_KIND1, 1'b0, 1'b1, outcome(ST_EMPTY, 1016));
		add_cell(24'hFF0000, ST_KIND2, 1'b1, 1'b1, outcome(ST_EMPTY, -1024));
		add_cell(24'hFFFFFF, ST_EMPTY, 1'b1, 1'b0, '0);
		add_write(CFG_WEIGHTS_A, 64'h8080_8080_8080_8080);
		add_write(CFG_WEIGHTS_B, 64'h8080_8080_8080_8080);
		add_cell(24'hFFFFFF, ST_EMPTY, 1'b0, 1'b1, outcome(ST_EMPTY, -3072));
		add_write(CFG_WEIGHTS_A, 64'h7F7F_7F7F_7F7F_7F7F);
		add_write(CFG_WEIGHTS_B, 64'h7F7F_7F7F_7F7F_7F7F);
		add_write(CFG_WEIGHTS_C, 64'h7F7F_7F7F_7F7F_7F7F);
		add_cell(24'hFFFFFF, ST_KIND1, 1'b0, 1'b1, outcome(ST_EMPTY, 3048));
		// Small weights; rule writes carry junk above bit 39 and use the last entry
		add_write(CFG_WEIGHTS_A, 64'h0101_0101_0101_0101);
		add_write(CFG_WEIGHTS_B, 64'h0101_0101_0101_0101);
		add_write(CFG_WEIGHTS_C, 64'h0202_0202_0202_0202);
		add_write(CFG_BORN_LOW, 64'h5A5A_5A00_0000_0004);
		add_write(CFG_BORN_HIGH, 64'h0000_0007_0000_0000);
		add_write(CFG_STAY_LOW, 64'hFFFF_FF00_0000_0001);
		add_write(CFG_STAY_HIGH, 64'h0000_0005_0000_0000);
		add_cell(24'h00000F, ST_EMPTY, 1'b1, 1'b0, '0);
		add_cell(24'h00007F, ST_EMPTY, 1'b0, 1'b0, '0);
		add_cell(24'h010007, ST_KIND2, 1'b0, 1'b0, '0);
		add_cell(24'h000000, ST_KIND1, 1'b1, 1'b0, '0);
		// a write to an unknown index must leave every register alone
		add_write(CFG_NO_REG, 64'h0);
		add_cell(24'h00000F, ST_EMPTY, 1'b0, 1'b0, '0);
		add_cell(24'h00007F, CENTER_UNUSED, 1'b1, 1'b0, '0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (plan[i]) begin
			step = plan[i];
			if (step.kind == STEP_WRITE) begin
				settle();
				write_reg(step.idx, step.data);
			end else begin
				send_cell(step.bits, step.center, step.parity, step.typed, step.outcome);
			end
		end
		directed_cells = cells_driven;

		// Random phases: new rule, then a stream of cells
		base = cells_driven;
		phases = 0;
		while (cells_driven - base < RANDOM_CELLS) begin
			settle();
			case ($urandom_range(0, 9))
				0:       wmode = FILL_FULL;
				1:       wmode = FILL_EXTREME;
				2, 3, 4, 5: wmode = FILL_SMALL;
				default: wmode = FILL_BINARY;
			endcase
			rmode = ($urandom_range(0, 7) == 0) ? FILL_FULL : FILL_RULE;
			if ($urandom_range(0, 3) != 0) write_reg(CFG_WEIGHTS_A, rand_bytes(wmode));
			if ($urandom_range(0, 3) != 0) write_reg(CFG_WEIGHTS_B, rand_bytes(wmode));
			if ($urandom_range(0, 3) != 0) write_reg(CFG_WEIGHTS_C, rand_bytes(wmode));
			write_reg(CFG_BORN_LOW, rand_bytes(rmode));
			if ($urandom_range(0, 1) != 0) write_reg(CFG_BORN_HIGH, rand_bytes(rmode));
			write_reg(CFG_STAY_LOW, rand_bytes(rmode));
			if ($urandom_range(0, 1) != 0) write_reg(CFG_STAY_HIGH, rand_bytes(rmode));
			if ($urandom_range(0, 9) == 0) write_reg(CFG_NO_REG, {$urandom, $urandom});

			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 25;
				default: idle_pct = 60;
			endcase
			dmode = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				// no gaps in the closing stretch
				if (cells_driven - base >= RANDOM_CELLS - CALM_TAIL) idle_pct = 0;
				pause_start(idle_pct);
				case (dmode)
					0:       bits = TAPS'($urandom);
					1:       bits = TAPS'($urandom & $urandom & $urandom);
					default: bits = TAPS'($urandom | $urandom);
				endcase
				center = ($urandom_range(0, 9) == 0) ? CENTER_UNUSED : 2'($urandom_range(0, 2));
				send_cell(bits, center, 1'($urandom), 1'b0, '0);
			end
			phases++;
		end

		settle();
		$display("checked %0d cells: %0d directed, the rest random across %0d rule settings",
		         cells_checked, directed_cells, phases);
		$display("%0d register writes, wide rule values and unknown-index writes among them",
		         writes_done);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
